// File: src/pfc_pkg.sv
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, field widths and reset values for the pump fill controller.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int unsigned LEVEL_W   = 10;
    localparam int unsigned TIMEOUT_W = 16;
    localparam int unsigned INDEX_W   = 4;
    localparam int unsigned SUM_W     = 14;
    localparam int unsigned TICKS_W   = 17;
    localparam int unsigned STATUS_W  = 3;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DAT_W = 16;

    localparam logic [LEVEL_W-1:0]   THRESHOLD_RST = LEVEL_W'(400);
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST   = TIMEOUT_W'(200);
    localparam logic [TICKS_W-1:0]   TICKS_MAX     = {TICKS_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEVEL_THRESHOLD = 2'd0,
        REG_TIMEOUT_TICKS   = 2'd1
    } t_cfg_reg;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_IDLE    = 3'd0,
        STATUS_PUMPING = 3'd1,
        STATUS_FULL    = 3'd2,
        STATUS_SUCCESS = 3'd3,
        STATUS_TIMEOUT = 3'd4
    } t_status;

    typedef struct packed {
        logic [LEVEL_W-1:0]   level_threshold;
        logic [TIMEOUT_W-1:0] timeout_ticks;
    } t_cfg;

    typedef struct packed {
        logic                 busy;
        logic [INDEX_W-1:0]   sample_index;
        logic [SUM_W-1:0]     sample_sum;
        logic [TICKS_W-1:0]   elapsed_ticks;
        logic [LEVEL_W-1:0]   last_average;
    } t_state;

endpackage

// File: src/pump_fill_controller_core.sv
// ----------------------------------------------------------------------------
// pump_fill_controller_core
// Pump fill controller: start and tick requests in, one status result out.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  --------+---------------------------+-----------------------------------
//  in      | i_in_valid / o_in_ready   | i_command, i_level_sample
//  out     | o_out_valid / i_out_ready | o_status, o_pump_on, o_average_level
//  cfg     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
//  One request per cycle unless the output stalls; the result appears in the
//  output register in the cycle after acceptance. A request is taken whenever
//  the output register is empty or being drained in the same cycle. Synchronous
//  reset returns to idle with default thresholds; there is no clearing pass.
// ----------------------------------------------------------------------------
module pump_fill_controller_core #(
    parameter int unsigned SAMPLES_PER_AVERAGE = 7
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [pfc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [pfc_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_command,
    input  logic [pfc_pkg::LEVEL_W-1:0]       i_level_sample,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [pfc_pkg::STATUS_W-1:0]      o_status,
    output logic                              o_pump_on,
    output logic [pfc_pkg::LEVEL_W-1:0]       o_average_level
);
    import pfc_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_status n_status;
    logic    n_pump_on;
    logic    r_out_valid;
    t_status r_status;
    logic    r_pump_on;
    logic [LEVEL_W-1:0] r_average;
    logic    in_fire;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    pfc_step #(
        .SAMPLES_PER_AVERAGE (SAMPLES_PER_AVERAGE)
    ) u_step (
        .i_cfg          (r_cfg),
        .i_state        (r_state),
        .i_command      (i_command),
        .i_level_sample (i_level_sample),
        .o_state        (n_state),
        .o_status       (n_status),
        .o_pump_on      (n_pump_on)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.level_threshold <= THRESHOLD_RST;
            r_cfg.timeout_ticks   <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LEVEL_THRESHOLD: r_cfg.level_threshold <= i_cfg_data[LEVEL_W-1:0];
                REG_TIMEOUT_TICKS:   r_cfg.timeout_ticks   <= i_cfg_data[TIMEOUT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_status  <= n_status;
            r_pump_on <= n_pump_on;
            r_average <= n_state.last_average;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_pump_on       = r_pump_on;
    assign o_average_level = r_average;

    a_pump_matches_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_pump_on == r_state.busy))
        else $error("pump_on disagrees with busy state");

    a_average_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_average_level == r_state.last_average))
        else $error("average_level disagrees with stored average");

    a_done_stops_pump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == STATUS_SUCCESS || o_status == STATUS_TIMEOUT
                         || o_status == STATUS_FULL)) |-> !o_pump_on)
        else $error("pump left on after terminal status");

    a_index_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_state.sample_index} < 5'(SAMPLES_PER_AVERAGE))
        || (SAMPLES_PER_AVERAGE >= (1 << INDEX_W)))
        else $error("sample index outside averaging block");

    a_idle_clears_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && !r_state.busy && i_command) |=> $stable(r_state))
        else $error("tick while idle changed state");

endmodule

// File: src/pfc_step.sv
// ----------------------------------------------------------------------------
// pfc_step
// Next controller state and result for one request.
// ----------------------------------------------------------------------------
module pfc_step #(
    parameter int unsigned SAMPLES_PER_AVERAGE = 7
) (
    input  pfc_pkg::t_cfg                   i_cfg,
    input  pfc_pkg::t_state                 i_state,
    input  logic                            i_command,
    input  logic [pfc_pkg::LEVEL_W-1:0]     i_level_sample,
    output pfc_pkg::t_state                 o_state,
    output pfc_pkg::t_status                o_status,
    output logic                            o_pump_on
);
    import pfc_pkg::*;

    localparam int unsigned N_W       = 5;
    localparam int unsigned DIV_SHIFT = SUM_W + 4;
    localparam int unsigned MULT_W    = DIV_SHIFT + 1;
    localparam int unsigned PROD_W    = SUM_W + MULT_W;
    localparam int unsigned LIMIT_W   = LEVEL_W + N_W;
    localparam logic [N_W-1:0]    N_VAL    = N_W'(SAMPLES_PER_AVERAGE);
    localparam logic [MULT_W-1:0] DIV_MULT =
        MULT_W'(((64'd1 << DIV_SHIFT) + SAMPLES_PER_AVERAGE - 1) / SAMPLES_PER_AVERAGE);

    logic [INDEX_W-1:0] idx_inc;
    logic [SUM_W-1:0]   sum_inc;
    logic [TICKS_W-1:0] ticks_inc;
    logic               block_done;
    logic [PROD_W-1:0]  quot_prod;
    logic [LIMIT_W-1:0] fill_limit;
    logic               reached;
    logic               timed_out;

    assign idx_inc    = i_state.sample_index + INDEX_W'(1);
    assign sum_inc    = i_state.sample_sum + SUM_W'(i_level_sample);
    assign ticks_inc  = (i_state.elapsed_ticks == TICKS_MAX) ? TICKS_MAX
                        : i_state.elapsed_ticks + TICKS_W'(1);
    assign block_done = {1'b0, idx_inc} >= N_VAL;
    assign quot_prod  = PROD_W'(sum_inc) * PROD_W'(DIV_MULT);
    assign fill_limit = LIMIT_W'(i_cfg.level_threshold) * LIMIT_W'(N_VAL);
    assign reached    = block_done && (LIMIT_W'(sum_inc) >= fill_limit);
    assign timed_out  = ticks_inc > TICKS_W'(i_cfg.timeout_ticks);

    always_comb begin
        o_state   = i_state;
        o_status  = STATUS_IDLE;
        o_pump_on = i_state.busy;
        if (!i_command) begin
            if (i_state.busy) begin
                o_status = STATUS_IDLE;
            end else if (i_level_sample >= i_cfg.level_threshold) begin
                o_status = STATUS_FULL;
            end else begin
                o_state.busy          = 1'b1;
                o_state.sample_index  = '0;
                o_state.sample_sum    = '0;
                o_state.elapsed_ticks = '0;
                o_status              = STATUS_PUMPING;
                o_pump_on             = 1'b1;
            end
        end else if (i_state.busy) begin
            o_state.elapsed_ticks = ticks_inc;
            if (block_done) begin
                o_state.sample_index = '0;
                o_state.sample_sum   = '0;
                o_state.last_average = quot_prod[DIV_SHIFT +: LEVEL_W];
            end else begin
                o_state.sample_index = idx_inc;
                o_state.sample_sum   = sum_inc;
            end
            if (timed_out) begin
                o_state.busy = 1'b0;
                o_status     = STATUS_TIMEOUT;
                o_pump_on    = 1'b0;
            end else if (reached) begin
                o_state.busy = 1'b0;
                o_status     = STATUS_SUCCESS;
                o_pump_on    = 1'b0;
            end else begin
                o_status  = STATUS_PUMPING;
                o_pump_on = 1'b1;
            end
        end
    end

endmodule
